// ----- src/qpht_pkg.sv -----
package qpht_pkg;

    localparam int TABLE_SLOTS = 64;
    localparam int KEY_BYTES   = 8;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
    localparam int KEY_W       = 64;
    localparam int VAL_W       = 32;
    localparam int HASH_SHL_A  = 6;
    localparam int HASH_SHL_B  = 16;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [2:0] ST_NEW       = 3'd0;
    localparam logic [2:0] ST_REPLACED  = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic load;       // latch operands, clear hash state
        logic hash_step;  // fold one key byte into hash
        logic probe_init; // probe index to 0, compute first slot
        logic probe_next; // advance probe index
        logic rd;         // issue slot read
        logic wr_new;     // write key/value, mark occupied
        logic wr_val;     // replace value
        logic clr;        // clear occupied flag
        logic hit_cap;    // capture found value and slot
    } qpht_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hash_done;
        logic last_probe;
        logic occupied;
        logic key_eq;
        logic [1:0] opcode;
    } qpht_sts_t;

endpackage

// ----- src/quadratic_probe_hash_table_top.sv -----
// Open-addressing key/value table of 64 slots, SDBM hash, quadratic probing.
// Pulse start while busy is low with opcode (0 insert/replace, 1 lookup,
// 2 remove), key (8 bytes, first in the top byte, zero byte ends it) and
// value. One transaction result appears for a single cycle with done high;
// the receiver cannot stall it, so capture it that cycle. Hashing folds
// the key bytes in order through the ending zero (at most 8), then the
// first slot is formed; each probe then steps through address, registered
// RAM read and compare. Insert stops at the first empty or matching
// slot; lookup/remove stop at the first match and a miss walks all 64 probes.
// A finishing step follows the last probe before done rises. Slot memories
// are not cleared; occupancy flags are reset at once, so the table is usable
// right after reset.
module quadratic_probe_hash_table_top
    import qpht_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        opcode,
    input  logic [KEY_W-1:0]  key,
    input  logic [VAL_W-1:0]  value,
    output logic              done,
    output logic [2:0]        status,
    output logic [VAL_W-1:0]  value_out,
    output logic [SLOT_W-1:0] slot_index,
    output logic [CNT_W-1:0]  entries_now
);
    qpht_cmd_t         cmd;
    qpht_sts_t         sts;
    logic [VAL_W-1:0]  hit_value;
    logic [SLOT_W-1:0] hit_slot, cur_slot;

    // probe datapath: hash unit, probe sequencer, slot memories
    qpht_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .opcode(opcode), .key(key), .value(value),
        .hit_value(hit_value), .hit_slot(hit_slot), .cur_slot(cur_slot)
    );

    // controller owns entry count and result registers
    qpht_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .sts(sts), .cmd(cmd), .hit_value(hit_value), .hit_slot(hit_slot),
        .cur_slot(cur_slot), .done(done), .status(status),
        .value_out(value_out), .slot_index(slot_index),
        .entries_now(entries_now)
    );
endmodule

// ----- src/qpht_ram.sv -----
module qpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- src/qpht_datapath.sv -----
module qpht_datapath
    import qpht_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  qpht_cmd_t        cmd,
    output qpht_sts_t        sts,
    input  logic [1:0]       opcode,
    input  logic [KEY_W-1:0] key,
    input  logic [VAL_W-1:0] value,
    output logic [VAL_W-1:0] hit_value,
    output logic [SLOT_W-1:0] hit_slot,
    output logic [SLOT_W-1:0] cur_slot
);
    localparam int BIDX_W = $clog2(KEY_BYTES + 1);

    logic [1:0]        op_reg;
    logic [KEY_W-1:0]  key_reg, shift_reg, shift_next;
    logic [VAL_W-1:0]  val_reg;
    logic [KEY_W-1:0]  hash_reg, hash_next;
    logic [BIDX_W-1:0] bcnt_reg;
    logic              hdone_reg;
    logic [SLOT_W:0]   pidx_reg;       // holds TABLE_SLOTS
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SLOT_W-1:0] rslot_reg;
    logic [TABLE_SLOTS-1:0] occ_reg;
    logic              occ_rd_reg;
    logic [KEY_W-1:0]  rkey;
    logic [VAL_W-1:0]  rval;
    logic [7:0]        cbyte;
    logic [SLOT_W:0]   pidx_next;
    logic [2*SLOT_W+1:0] sq;

    assign cbyte = shift_reg[KEY_W-1 -: 8];

    always_comb
    begin
        hash_next = KEY_W'(cbyte) + (hash_reg << HASH_SHL_A)
                  + (hash_reg << HASH_SHL_B) - hash_reg;
        shift_next = shift_reg << 8;
    end

    // (h + i*i) mod slots: only low bits matter
    assign pidx_next = pidx_reg + 1'b1;
    assign sq        = pidx_next * pidx_next;
    assign slot_next = hash_reg[SLOT_W-1:0] + sq[SLOT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg   <= '0;
            hdone_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                hdone_reg <= 1'b0;
            end
            else if (cmd.hash_step &&
                     (cbyte == 8'd0 || bcnt_reg == BIDX_W'(KEY_BYTES - 1)))
            begin
                hdone_reg <= 1'b1;
            end
            if (cmd.wr_new)
            begin
                occ_reg[rslot_reg] <= 1'b1;
            end
            if (cmd.clr)
            begin
                occ_reg[rslot_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= opcode;
            shift_reg <= key;
            key_reg   <= '0;
            val_reg   <= value;
            hash_reg  <= '0;
            bcnt_reg  <= '0;
        end
        else if (cmd.hash_step && !hdone_reg)
        begin
            if (cbyte != 8'd0)
            begin
                hash_reg <= hash_next;
                key_reg[KEY_W-1-8*bcnt_reg -: 8] <= cbyte;
            end
            shift_reg <= shift_next;
            bcnt_reg  <= bcnt_reg + 1'b1;
        end
        if (cmd.probe_init)
        begin
            pidx_reg <= '0;
            slot_reg <= hash_reg[SLOT_W-1:0];
        end
        else if (cmd.probe_next)
        begin
            pidx_reg <= pidx_next;
            slot_reg <= slot_next;
        end
        if (cmd.rd)
        begin
            rslot_reg  <= slot_reg;
            occ_rd_reg <= occ_reg[slot_reg];
        end
        if (cmd.hit_cap)
        begin
            hit_value <= rval;
            hit_slot  <= rslot_reg;
        end
    end

    qpht_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_SLOTS)) u_key_ram (
        .clk(clk), .we(cmd.wr_new), .waddr(rslot_reg), .wdata(key_reg),
        .raddr(slot_reg), .rdata(rkey)
    );

    qpht_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_SLOTS)) u_val_ram (
        .clk(clk), .we(cmd.wr_new | cmd.wr_val), .waddr(rslot_reg),
        .wdata(val_reg), .raddr(slot_reg), .rdata(rval)
    );

    assign cur_slot       = rslot_reg;
    assign sts.hash_done  = hdone_reg;
    assign sts.last_probe = (pidx_reg == (SLOT_W + 1)'(TABLE_SLOTS - 1));
    assign sts.occupied   = occ_rd_reg;
    assign sts.key_eq     = (rkey == key_reg);
    assign sts.opcode     = op_reg;
endmodule

// ----- src/qpht_ctrl.sv -----
module qpht_ctrl
    import qpht_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  qpht_sts_t         sts,
    output qpht_cmd_t         cmd,
    input  logic [VAL_W-1:0]  hit_value,
    input  logic [SLOT_W-1:0] hit_slot,
    input  logic [SLOT_W-1:0] cur_slot,
    output logic              done,
    output logic [2:0]        status,
    output logic [VAL_W-1:0]  value_out,
    output logic [SLOT_W-1:0] slot_index,
    output logic [CNT_W-1:0]  entries_now
);
    typedef enum logic [2:0] {S_IDLE, S_HASH, S_PROBE, S_READ, S_EVAL, S_FIN} state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [2:0]        st_reg, st_next;
    logic              found_reg, found_next;
    logic [SLOT_W-1:0] wslot_reg, wslot_next;
    logic              done_next;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        st_next    = st_reg;
        found_next = found_reg;
        wslot_next = wslot_reg;
        done_next  = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    found_next = 1'b0;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                cmd.hash_step = 1'b1;
                if (sts.hash_done)
                begin
                    cmd.hash_step  = 1'b0;
                    cmd.probe_init = 1'b1;
                    if (sts.opcode == OP_INSERT)
                    begin
                        st_next = ST_FULL;
                    end
                    else
                    begin
                        st_next = ST_NOT_FOUND;
                    end
                    state_next = (sts.opcode == OP_UNUSED) ? S_FIN : S_PROBE;
                end
            end
            S_PROBE:
            begin
                cmd.rd     = 1'b1;
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_PROBE;
                if (sts.opcode == OP_INSERT)
                begin
                    if (!sts.occupied)
                    begin
                        cmd.wr_new = 1'b1;
                        st_next    = ST_NEW;
                        wslot_next = cur_slot;
                        found_next = 1'b1;
                        count_next = count_reg + 1'b1;
                        state_next = S_FIN;
                    end
                    else if (sts.key_eq)
                    begin
                        cmd.wr_val = 1'b1;
                        st_next    = ST_REPLACED;
                        wslot_next = cur_slot;
                        found_next = 1'b1;
                        state_next = S_FIN;
                    end
                end
                else if (sts.occupied && sts.key_eq)
                begin
                    cmd.hit_cap = 1'b1;
                    st_next     = ST_FOUND;
                    found_next  = 1'b1;
                    if (sts.opcode == OP_REMOVE)
                    begin
                        cmd.clr = 1'b1;
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                    state_next = S_FIN;
                end
                if (state_next == S_PROBE)
                begin
                    if (sts.last_probe)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        cmd.probe_next = 1'b1;
                    end
                end
            end
            S_FIN:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            st_reg    <= ST_NOT_FOUND;
            found_reg <= 1'b0;
            wslot_reg <= '0;
            done      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            st_reg    <= st_next;
            found_reg <= found_next;
            wslot_reg <= wslot_next;
            done      <= done_next;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign status      = st_reg;
    assign entries_now = count_reg;
    always_comb
    begin
        value_out  = '0;
        slot_index = '0;
        if (found_reg)
        begin
            if (st_reg == ST_FOUND)
            begin
                value_out  = hit_value;
                slot_index = hit_slot;
            end
            else
            begin
                slot_index = wslot_reg;
            end
        end
    end
endmodule

// ----- src/qpht_checker.sv -----
module qpht_checker
    import qpht_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input logic [2:0]        status,
    input logic [VAL_W-1:0]  value_out,
    input logic [CNT_W-1:0]  entries_now
);
    // accepted transaction makes block busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("not busy after start");
    // result strobe lasts one cycle
    a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held");
    // count changes only in the cycle before a result
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        $changed(entries_now) |=> done) else $error("count moved");
    // value only on found
    a_val: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_FOUND) |-> value_out == '0) else $error("value leak");
    a_st: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> status <= ST_FULL) else $error("bad status");
endmodule

bind quadratic_probe_hash_table_top qpht_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .status(status), .value_out(value_out), .entries_now(entries_now)
);

// ----- test/quadratic_probe_hash_table_top_test.sv -----
`timescale 1ns / 100ps

module quadratic_probe_hash_table_top_test;
    import qpht_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        opcode;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    logic              done;
    logic [2:0]        status;
    logic [VAL_W-1:0]  value_out;
    logic [SLOT_W-1:0] slot_index;
    logic [CNT_W-1:0]  entries_now;

    quadratic_probe_hash_table_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .key         (key),
        .value       (value),
        .done        (done),
        .status      (status),
        .value_out   (value_out),
        .slot_index  (slot_index),
        .entries_now (entries_now)
    );

    // one table response
    typedef struct packed {
        logic [2:0]        status;
        logic [VAL_W-1:0]  value_out;
        logic [SLOT_W-1:0] slot_index;
        logic [CNT_W-1:0]  entries_now;
    } table_resp_t;

    // directed row; chk marks a response typed in by hand
    typedef struct {
        logic [1:0]       op;
        logic [KEY_W-1:0] k;
        logic [VAL_W-1:0] v;
        bit               chk;
        table_resp_t      resp;
    } dir_row_t;

    // shadow copy of the table
    logic              shadow_occ [TABLE_SLOTS];
    logic [KEY_W-1:0]  shadow_key [TABLE_SLOTS];
    logic [VAL_W-1:0]  shadow_val [TABLE_SLOTS];
    int unsigned       shadow_count;

    table_resp_t pending_resp [$];
    int unsigned fail_count;
    int unsigned sent_count;

    // small key pool so repeats, replaces and hits are common
    logic [KEY_W-1:0] key_pool [16];

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // zero the bytes after the terminator
    function automatic logic [KEY_W-1:0] trim_key(input logic [KEY_W-1:0] raw);
        logic [KEY_W-1:0] res;
        logic [7:0]       b;
        bit               ended;
        res = '0;
        ended = 0;
        for (int k = 0; k < KEY_BYTES; k++)
        begin
            b = raw[63 - 8*k -: 8];
            if (b == 8'd0)
                ended = 1;
            if (!ended)
                res[63 - 8*k -: 8] = b;
        end
        return res;
    endfunction

    function automatic logic [63:0] sdbm_hash(input logic [KEY_W-1:0] ck);
        logic [63:0] h;
        logic [7:0]  c;
        h = '0;
        for (int k = 0; k < 8; k++)
        begin
            c = ck[63 - 8*k -: 8];
            if (c == 8'd0)
                break;
            h = {56'd0, c} + (h << HASH_SHL_A) + (h << HASH_SHL_B) - h;
        end
        return h;
    endfunction

    // apply one transaction to the shadow table, return the response
    function automatic table_resp_t table_apply(input logic [1:0] op,
                                                input logic [KEY_W-1:0] raw,
                                                input logic [VAL_W-1:0] v);
        table_resp_t      r;
        logic [KEY_W-1:0] ck;
        logic [63:0]      h;
        logic [63:0]      s64;
        int unsigned      s;
        ck = trim_key(raw);
        h = sdbm_hash(ck);
        r.status = ST_NOT_FOUND;
        r.value_out = '0;
        r.slot_index = '0;
        if (op == OP_INSERT)
        begin
            r.status = ST_FULL;
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                s64 = h + 64'(i) * 64'(i);
                s = 32'(s64 % TABLE_SLOTS);
                if (!shadow_occ[s])
                begin
                    shadow_occ[s] = 1'b1;
                    shadow_key[s] = ck;
                    shadow_val[s] = v;
                    shadow_count++;
                    r.status = ST_NEW;
                    r.slot_index = s[SLOT_W-1:0];
                    break;
                end
                if (shadow_key[s] == ck)
                begin
                    shadow_val[s] = v;
                    r.status = ST_REPLACED;
                    r.slot_index = s[SLOT_W-1:0];
                    break;
                end
            end
        end
        else if (op == OP_LOOKUP || op == OP_REMOVE)
        begin
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                s64 = h + 64'(i) * 64'(i);
                s = 32'(s64 % TABLE_SLOTS);
                if (shadow_occ[s] && shadow_key[s] == ck)
                begin
                    r.status = ST_FOUND;
                    r.value_out = shadow_val[s];
                    r.slot_index = s[SLOT_W-1:0];
                    if (op == OP_REMOVE)
                    begin
                        shadow_occ[s] = 1'b0;
                        if (shadow_count > 0)
                            shadow_count--;
                    end
                    break;
                end
            end
        end
        r.entries_now = shadow_count[CNT_W-1:0];
        return r;
    endfunction

    task automatic idle_gap();
        int unsigned n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            n = 0;
        repeat (n) @(posedge clk);
    endtask

    // issue one transaction; start held for a single accepting edge
    task automatic send_txn(input logic [1:0] op, input logic [KEY_W-1:0] k,
                            input logic [VAL_W-1:0] v, input bit chk,
                            input table_resp_t typed);
        table_resp_t p;
        while (busy)
            @(posedge clk);
        start <= 1'b1;
        opcode <= op;
        key <= k;
        value <= v;
        p = table_apply(op, k, v);
        if (chk && p != typed)
        begin
            $error("typed row disagrees with predictor: %h vs %h", typed, p);
            fail_count++;
        end
        pending_resp.push_back(p);
        sent_count++;
        @(posedge clk);
        start <= 1'b0;
        opcode <= 2'($urandom());
        key <= {$urandom(), $urandom()};
        value <= $urandom();
        // wait for busy to rise so the next check sees the new transaction
        @(posedge clk);
    endtask

    // result checker: sample at the edge ending the done cycle
    always @(posedge clk)
    begin
        table_resp_t e;
        if (rst_n && done)
        begin
            if (pending_resp.size() == 0)
            begin
                $error("result with nothing expected: status %0d", status);
                fail_count++;
            end
            else
            begin
                e = pending_resp.pop_front();
                if (status !== e.status)
                begin
                    $error("status expected %0d actual %0d", e.status, status);
                    fail_count++;
                end
                if (value_out !== e.value_out)
                begin
                    $error("value_out expected %h actual %h", e.value_out, value_out);
                    fail_count++;
                end
                if (slot_index !== e.slot_index)
                begin
                    $error("slot_index expected %0d actual %0d", e.slot_index, slot_index);
                    fail_count++;
                end
                if (entries_now !== e.entries_now)
                begin
                    $error("entries_now expected %0d actual %0d", e.entries_now,
                           entries_now);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        dir_row_t    rows [$];
        dir_row_t    row;
        table_resp_t none;
        logic [1:0]  op;
        logic [KEY_W-1:0] k;
        int unsigned pick;
        int unsigned waited;

        none = '0;
        rst_n = 1'b0;
        start = 1'b0;
        opcode = OP_INSERT;
        key = '0;
        value = '0;
        fail_count = 0;
        sent_count = 0;
        shadow_count = 0;
        for (int s = 0; s < TABLE_SLOTS; s++)
        begin
            shadow_occ[s] = 1'b0;
            shadow_key[s] = '0;
            shadow_val[s] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table misses, empty key, extremes, replace, remove,
        // unused opcode, bytes after the terminator ignored
        rows.push_back('{OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 1,
                         '{ST_NOT_FOUND, 32'h0, 6'd0, 7'd0}});
        rows.push_back('{OP_REMOVE, 64'h0, 32'h0, 1, '{ST_NOT_FOUND, 32'h0, 6'd0, 7'd0}});
        rows.push_back('{OP_INSERT, 64'h0, 32'hFFFF_FFFF, 1, '{ST_NEW, 32'h0, 6'd0, 7'd1}});
        rows.push_back('{OP_INSERT, 64'h0012_3456_789A_BCDE, 32'h1, 1,
                         '{ST_REPLACED, 32'h0, 6'd0, 7'd1}});
        rows.push_back('{OP_LOOKUP, 64'h0, 32'h0, 1, '{ST_FOUND, 32'h1, 6'd0, 7'd1}});
        rows.push_back('{OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 0, none});
        rows.push_back('{OP_INSERT, 64'h4100_FFFF_FFFF_FFFF, 32'hA5A5_A5A5, 0, none});
        rows.push_back('{OP_LOOKUP, 64'h4100_0000_0000_0000, 32'h0, 0, none});
        rows.push_back('{OP_INSERT, 64'h0102_0408_1020_4080, 32'h5A5A_5A5A, 0, none});
        rows.push_back('{OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 0, none});
        rows.push_back('{OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 0, none});
        rows.push_back('{OP_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 0, none});
        rows.push_back('{OP_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 0, none});
        rows.push_back('{OP_LOOKUP, 64'h0102_0408_1020_4080, 32'h0, 0, none});
        rows.push_back('{OP_REMOVE, 64'h0, 32'h0, 0, none});
        foreach (rows[i])
        begin
            row = rows[i];
            send_txn(row.op, row.k, row.v, row.chk, row.resp);
            idle_gap();
        end

        // fill until full so the table-full path is hit, then random mix
        for (int n = 0; n < 90; n++)
        begin
            send_txn(OP_INSERT, {$urandom(), $urandom()}, $urandom(), 0, none);
            if ($urandom_range(0, 4) == 0)
                idle_gap();
        end
        for (int n = 0; n < 80; n++)
        begin
            send_txn(OP_REMOVE, {$urandom(), $urandom()}, $urandom(), 0, none);
        end

        for (int p = 0; p < 16; p++)
            key_pool[p] = {$urandom(), $urandom()} << (8 * $urandom_range(0, 7));
        for (int n = 0; n < 1300; n++)
        begin
            pick = $urandom_range(0, 99);
            op = (pick < 45) ? OP_INSERT : (pick < 75) ? OP_LOOKUP :
                 (pick < 98) ? OP_REMOVE : OP_UNUSED;
            if ($urandom_range(0, 3) == 0)
                k = {$urandom(), $urandom()};
            else
                k = key_pool[$urandom_range(0, 15)];
            send_txn(op, k, $urandom(), 0, none);
            if ($urandom_range(0, 2) == 0)
                idle_gap();
        end

        waited = 0;
        while (pending_resp.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (300) @(posedge clk);
        if (fail_count == 0 && pending_resp.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
